// ===== hw/rtl/pbs_pkg.sv =====
// pbs_pkg: field widths and packed item layouts for the priority batch scheduler
// no dependencies; imported by priority_batch_scheduler_unit
package pbs_pkg;

  localparam int ID_W    = 16;
  localparam int BURST_W = 16;
  localparam int PRIO_W  = 8;
  localparam int TIME_W  = 20;
  localparam int AVG_W   = 28;
  localparam int FRAC_W  = 8;

  // one stored job, id in the lowest bits
  typedef struct packed {
    logic [PRIO_W-1:0]  prio;
    logic [BURST_W-1:0] burst;
    logic [ID_W-1:0]    id;
  } job_t;

  localparam int JOB_W = $bits(job_t);

  // one result item, job id in the lowest bits
  typedef struct packed {
    logic [AVG_W-1:0]   avg_turnaround;
    logic [AVG_W-1:0]   avg_waiting;
    logic [TIME_W-1:0]  turnaround_time;
    logic [TIME_W-1:0]  waiting_time;
    logic [BURST_W-1:0] burst_time_res;
    logic [ID_W-1:0]    job_id_res;
  } res_t;

  localparam int RES_W = $bits(res_t);

endpackage

// ===== hw/rtl/priority_batch_scheduler_unit.sv =====
// priority_batch_scheduler_unit: loads jobs into a sorted job memory, then emits
// them in run order with waiting/turnaround times and batch averages; uses pbs_pkg
//
//  channel | group | payload (low bit first)                          | marker
//  input   | in_   | tdata: job_id, burst_time, priority_req          | tlast: last
//  result  | out_  | tdata: job_id_res, burst_time_res, waiting_time, | tlast: end_of_batch
//          |       |   turnaround_time, avg_waiting, avg_turnaround   | tuser: overflow
//
// a job is inserted into its place in the job memory (descending priority, ties in
// arrival order) by moving the lower entries up one a cycle, then writing the job
// itself; the input is not ready meanwhile. the memory has one read port and one
// write port.
// after a job marked last the results are emitted in run order, and the averages are
// found by shift-subtract division before the final result carries them out.
// the result register frees the output side: emission waits only when it is still full.
// rst_n clears the job count and drop flag; the memory is not cleared.
module priority_batch_scheduler_unit
  import pbs_pkg::*;
#(
  parameter int MAX_JOBS = 16
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_tvalid,
  output logic             in_tready,
  input  logic [JOB_W-1:0] in_tdata,   // job_id, burst_time, priority_req
  input  logic             in_tlast,   // last
  output logic             out_tvalid,
  input  logic             out_tready,
  output logic [RES_W-1:0] out_tdata,  // job_id_res, burst_time_res, waiting_time,
                                       // turnaround_time, avg_waiting, avg_turnaround
  output logic             out_tuser,  // overflow
  output logic             out_tlast   // end_of_batch
);

  localparam int CNT_W  = $clog2(MAX_JOBS + 1);
  localparam int IDX_W  = $clog2(MAX_JOBS);
  localparam int SUM_W  = BURST_W + 2 * CNT_W;
  localparam int DW     = SUM_W + FRAC_W;
  localparam int DCNT_W = $clog2(DW + 1);

  typedef enum logic [2:0] {
    S_IDLE,
    S_CMP,
    S_PUT,
    S_EMIT,
    S_DIV,
    S_FIN
  } state_t;

  // job memory, one read and one write port; a write forwards to a read of the same entry
  job_t             mem [MAX_JOBS];
  logic             rd_en;
  logic [IDX_W-1:0] rd_addr;
  job_t             rd_data_r;
  logic             wr_en;
  logic [IDX_W-1:0] wr_addr;
  job_t             wr_data;

  state_t           state_r, state_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic             dropped_r, dropped_nxt;
  logic             last_r, last_nxt;
  job_t             new_r, new_nxt;
  logic [IDX_W-1:0] j_r, j_nxt;
  logic [IDX_W-1:0] k_r, k_nxt;
  logic [SUM_W-1:0] wait_r, wait_nxt;
  logic [SUM_W-1:0] tot_w_r, tot_w_nxt;
  logic [SUM_W-1:0] tot_t_r, tot_t_nxt;
  logic [DW-1:0]    dvd_w_r, dvd_w_nxt;
  logic [DW-1:0]    dvd_t_r, dvd_t_nxt;
  logic [CNT_W:0]   rem_w_r, rem_w_nxt;
  logic [CNT_W:0]   rem_t_r, rem_t_nxt;
  logic [DCNT_W-1:0] dcnt_r, dcnt_nxt;

  logic             out_valid_r, out_valid_nxt;
  res_t             out_data_r, out_data_nxt;
  logic             out_user_r, out_user_nxt;
  logic             out_last_r, out_last_nxt;

  logic             in_xfer;
  logic             out_free;
  job_t             in_job;
  logic [CNT_W-1:0] cnt_m1;
  logic [SUM_W-1:0] turn;
  logic             is_final;
  logic [CNT_W:0]   trial_w, trial_t;
  logic [CNT_W:0]   divisor;

  assign in_tready  = (state_r == S_IDLE);
  assign in_xfer    = in_tvalid && in_tready;
  assign in_job     = job_t'(in_tdata);
  assign out_free   = !out_valid_r || out_tready;
  assign cnt_m1     = count_r - 1'b1;
  assign turn       = wait_r + SUM_W'(rd_data_r.burst);
  assign is_final   = (k_r == cnt_m1[IDX_W-1:0]);
  assign divisor    = {1'b0, count_r};
  assign trial_w    = {rem_w_r[CNT_W-1:0], dvd_w_r[DW-1]};
  assign trial_t    = {rem_t_r[CNT_W-1:0], dvd_t_r[DW-1]};

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_user_r;
  assign out_tlast  = out_last_r;

  always_comb begin
    state_nxt     = state_r;
    count_nxt     = count_r;
    dropped_nxt   = dropped_r;
    last_nxt      = last_r;
    new_nxt       = new_r;
    j_nxt         = j_r;
    k_nxt         = k_r;
    wait_nxt      = wait_r;
    tot_w_nxt     = tot_w_r;
    tot_t_nxt     = tot_t_r;
    dvd_w_nxt     = dvd_w_r;
    dvd_t_nxt     = dvd_t_r;
    rem_w_nxt     = rem_w_r;
    rem_t_nxt     = rem_t_r;
    dcnt_nxt      = dcnt_r;
    out_valid_nxt = out_valid_r && !out_tready;
    out_data_nxt  = out_data_r;
    out_user_nxt  = out_user_r;
    out_last_nxt  = out_last_r;
    rd_en         = 1'b0;
    rd_addr       = '0;
    wr_en         = 1'b0;
    wr_addr       = j_r;
    wr_data       = new_r;

    case (state_r)
      S_IDLE: begin
        if (in_xfer) begin
          new_nxt  = in_job;
          last_nxt = in_tlast;
          if (count_r < CNT_W'(MAX_JOBS)) begin
            j_nxt = count_r[IDX_W-1:0];
            if (count_r == '0) begin
              state_nxt = S_PUT;
            end else begin
              rd_en     = 1'b1;
              rd_addr   = cnt_m1[IDX_W-1:0];
              state_nxt = S_CMP;
            end
          end else begin
            dropped_nxt = 1'b1;
            if (in_tlast) begin
              rd_en     = 1'b1;
              rd_addr   = '0;
              k_nxt     = '0;
              wait_nxt  = '0;
              tot_w_nxt = '0;
              tot_t_nxt = '0;
              state_nxt = S_EMIT;
            end
          end
        end
      end

      // rd_data_r holds entry j-1: move it up while it ranks strictly lower
      S_CMP: begin
        if (rd_data_r.prio < new_r.prio) begin
          wr_en   = 1'b1;
          wr_addr = j_r;
          wr_data = rd_data_r;
          j_nxt   = j_r - 1'b1;
          if (j_r == IDX_W'(1)) begin
            state_nxt = S_PUT;
          end else begin
            rd_en   = 1'b1;
            rd_addr = j_r - IDX_W'(2);
          end
        end else begin
          state_nxt = S_PUT;
        end
      end

      S_PUT: begin
        wr_en     = 1'b1;
        wr_addr   = j_r;
        wr_data   = new_r;
        count_nxt = count_r + 1'b1;
        if (last_r) begin
          rd_en     = 1'b1;
          rd_addr   = '0;
          k_nxt     = '0;
          wait_nxt  = '0;
          tot_w_nxt = '0;
          tot_t_nxt = '0;
          state_nxt = S_EMIT;
        end else begin
          state_nxt = S_IDLE;
        end
      end

      // rd_data_r holds the job at run position k
      S_EMIT: begin
        if (is_final) begin
          tot_w_nxt = tot_w_r + wait_r;
          tot_t_nxt = tot_t_r + turn;
          dvd_w_nxt = {tot_w_nxt, FRAC_W'(0)};
          dvd_t_nxt = {tot_t_nxt, FRAC_W'(0)};
          rem_w_nxt = '0;
          rem_t_nxt = '0;
          dcnt_nxt  = DCNT_W'(DW);
          state_nxt = S_DIV;
        end else if (out_free) begin
          out_valid_nxt                = 1'b1;
          out_data_nxt.job_id_res      = rd_data_r.id;
          out_data_nxt.burst_time_res  = rd_data_r.burst;
          out_data_nxt.waiting_time    = wait_r[TIME_W-1:0];
          out_data_nxt.turnaround_time = turn[TIME_W-1:0];
          out_data_nxt.avg_waiting     = '0;
          out_data_nxt.avg_turnaround  = '0;
          out_user_nxt                 = dropped_r;
          out_last_nxt                 = 1'b0;
          tot_w_nxt = tot_w_r + wait_r;
          tot_t_nxt = tot_t_r + turn;
          wait_nxt  = turn;
          k_nxt     = k_r + 1'b1;
          rd_en     = 1'b1;
          rd_addr   = k_r + 1'b1;
        end
      end

      // restoring division, one quotient bit per cycle for both averages
      S_DIV: begin
        if (trial_w >= divisor) begin
          rem_w_nxt = trial_w - divisor;
          dvd_w_nxt = {dvd_w_r[DW-2:0], 1'b1};
        end else begin
          rem_w_nxt = trial_w;
          dvd_w_nxt = {dvd_w_r[DW-2:0], 1'b0};
        end
        if (trial_t >= divisor) begin
          rem_t_nxt = trial_t - divisor;
          dvd_t_nxt = {dvd_t_r[DW-2:0], 1'b1};
        end else begin
          rem_t_nxt = trial_t;
          dvd_t_nxt = {dvd_t_r[DW-2:0], 1'b0};
        end
        dcnt_nxt = dcnt_r - 1'b1;
        if (dcnt_r == DCNT_W'(1)) begin
          state_nxt = S_FIN;
        end
      end

      S_FIN: begin
        if (out_free) begin
          out_valid_nxt                = 1'b1;
          out_data_nxt.job_id_res      = rd_data_r.id;
          out_data_nxt.burst_time_res  = rd_data_r.burst;
          out_data_nxt.waiting_time    = wait_r[TIME_W-1:0];
          out_data_nxt.turnaround_time = turn[TIME_W-1:0];
          out_data_nxt.avg_waiting     = dvd_w_r[AVG_W-1:0];
          out_data_nxt.avg_turnaround  = dvd_t_r[AVG_W-1:0];
          out_user_nxt                 = dropped_r;
          out_last_nxt                 = 1'b1;
          count_nxt   = '0;
          dropped_nxt = 1'b0;
          state_nxt   = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      if (wr_en && (wr_addr == rd_addr)) begin
        rd_data_r <= wr_data;
      end else begin
        rd_data_r <= mem[rd_addr];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      dropped_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      dropped_r   <= dropped_nxt;
      out_valid_r <= out_valid_nxt;
    end
    last_r     <= last_nxt;
    new_r      <= new_nxt;
    j_r        <= j_nxt;
    k_r        <= k_nxt;
    wait_r     <= wait_nxt;
    tot_w_r    <= tot_w_nxt;
    tot_t_r    <= tot_t_nxt;
    dvd_w_r    <= dvd_w_nxt;
    dvd_t_r    <= dvd_t_nxt;
    rem_w_r    <= rem_w_nxt;
    rem_t_r    <= rem_t_nxt;
    dcnt_r     <= dcnt_nxt;
    out_data_r <= out_data_nxt;
    out_user_r <= out_user_nxt;
    out_last_r <= out_last_nxt;
  end

endmodule

// ===== tb/tb_priority_batch_scheduler_unit.sv =====
// tb_priority_batch_scheduler_unit: self-checking bench for priority_batch_scheduler_unit
// loads job batches over the input stream and checks the schedule against a local predictor
// depends on pbs_pkg and priority_batch_scheduler_unit
module tb_priority_batch_scheduler_unit;
  import pbs_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int JOBS_CAP     = 16;
  localparam int RANDOM_ITEMS = 300;
  localparam int HOLD_AT      = 80;    // jobs loaded before the long output hold-off
  localparam int HOLD_CYCLES  = 300;
  localparam int TAIL_CYCLES  = 64;    // insertion plus the averaging divide
  localparam int WATCHDOG     = 2000;

  typedef struct {
    res_t res;
    logic ovf;
    logic eob;
  } sched_res_t;

  typedef struct {
    job_t job;
    bit   last;
    bit   typed;
    res_t exp_res;
  } stim_row_t;

  logic             clk;
  logic             rst_n;
  logic             in_tvalid;
  logic             in_tready;
  logic [JOB_W-1:0] in_tdata;   // job_id, burst_time, priority_req
  logic             in_tlast;   // last
  logic             out_tvalid;
  logic             out_tready;
  logic [RES_W-1:0] out_tdata;  // job_id_res, burst_time_res, waiting_time,
                                // turnaround_time, avg_waiting, avg_turnaround
  logic             out_tuser;  // overflow
  logic             out_tlast;  // end_of_batch

  sched_res_t pending_results[$];
  job_t       loaded_jobs[$];
  bit         batch_dropped;
  int         mismatches;
  int         jobs_in;
  int         batches_done;
  int         drop_batches;
  int         results_seen;
  int         burst_left;
  int         idle_cycles;
  bit         hold_done;
  stim_row_t  dir_rows[$];

  priority_batch_scheduler_unit #(
    .MAX_JOBS(JOBS_CAP)
  ) uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tlast  (in_tlast),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser),
    .out_tlast (out_tlast)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // stores the job, and on the last one of a batch queues its results in run order
  task automatic schedule_job(input job_t job, input bit last, input bit typed,
                              input res_t typed_res);
    job_t        run_order[$];
    int          pos;
    int          n;
    logic [31:0] start_t;
    logic [31:0] turn;
    logic [63:0] tot_wait;
    logic [63:0] tot_turn;
    logic [63:0] avg;
    sched_res_t  r;
    if (loaded_jobs.size() < JOBS_CAP) loaded_jobs.push_back(job);
    else batch_dropped = 1'b1;
    if (!last) return;
    foreach (loaded_jobs[i]) begin
      pos = run_order.size();
      for (int k = 0; k < run_order.size(); k++) begin
        if (run_order[k].prio < loaded_jobs[i].prio) begin
          pos = k;
          break;
        end
      end
      run_order.insert(pos, loaded_jobs[i]);
    end
    n = run_order.size();
    if (typed) begin
      r.res = typed_res;
      r.ovf = 1'b0;
      r.eob = 1'b1;
      pending_results.push_back(r);
    end else begin
      start_t  = '0;
      tot_wait = '0;
      tot_turn = '0;
      for (int k = 0; k < n; k++) begin
        turn                  = start_t + 32'(run_order[k].burst);
        r.res                 = '0;
        r.res.job_id_res      = run_order[k].id;
        r.res.burst_time_res  = run_order[k].burst;
        r.res.waiting_time    = start_t[TIME_W-1:0];
        r.res.turnaround_time = turn[TIME_W-1:0];
        r.ovf                 = batch_dropped;
        r.eob                 = (k == n - 1);
        tot_wait              = tot_wait + 64'(start_t);
        tot_turn              = tot_turn + 64'(turn);
        if (k == n - 1) begin
          avg                  = (tot_wait << FRAC_W) / 64'(n);
          r.res.avg_waiting    = avg[AVG_W-1:0];
          avg                  = (tot_turn << FRAC_W) / 64'(n);
          r.res.avg_turnaround = avg[AVG_W-1:0];
        end
        pending_results.push_back(r);
        start_t = turn;
      end
    end
    batches_done++;
    if (batch_dropped) drop_batches++;
    loaded_jobs.delete();
    batch_dropped = 1'b0;
  endtask

  // offers one job, in bursts of random length with random gaps between them
  task automatic send_job(input job_t job, input bit last, input bit typed,
                          input res_t typed_res);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 5);
      if (gap > 0) begin
        in_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 12);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= job;
    in_tlast  <= last;
    do @(posedge clk); while (!in_tready);
    burst_left--;
    jobs_in++;
    schedule_job(job, last, typed, typed_res);
  endtask

  function automatic void check_field(string name, logic [63:0] exp_v, logic [63:0] act_v);
    if (exp_v !== act_v) begin
      $error("%s: expected %0d, actual %0d", name, exp_v, act_v);
      mismatches++;
    end
  endfunction

  // result checker, on every output transfer
  always @(posedge clk) begin
    sched_res_t e;
    res_t       got;
    if (rst_n && out_tvalid && out_tready) begin
      got = out_tdata;
      results_seen++;
      if (pending_results.size() == 0) begin
        $error("result with nothing expected: job_id_res %0d", got.job_id_res);
        mismatches++;
      end else begin
        e = pending_results.pop_front();
        check_field("job_id_res", 64'(e.res.job_id_res), 64'(got.job_id_res));
        check_field("burst_time_res", 64'(e.res.burst_time_res), 64'(got.burst_time_res));
        check_field("waiting_time", 64'(e.res.waiting_time), 64'(got.waiting_time));
        check_field("turnaround_time", 64'(e.res.turnaround_time),
                    64'(got.turnaround_time));
        check_field("avg_waiting", 64'(e.res.avg_waiting), 64'(got.avg_waiting));
        check_field("avg_turnaround", 64'(e.res.avg_turnaround), 64'(got.avg_turnaround));
        check_field("overflow", 64'(e.ovf), 64'(out_tuser));
        check_field("end_of_batch", 64'(e.eob), 64'(out_tlast));
      end
    end
  end

  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) idle_cycles = 0;
    else idle_cycles++;
    if (idle_cycles >= WATCHDOG) begin
      $display("timeout: no transfer for %0d cycles", WATCHDOG);
      $display("tb_priority_batch_scheduler_unit failed");
      $finish;
    end
  end

  // receiver: stretches of always-ready, random, one-in-four stall and stall-then-ready, plus one long hold-off
  initial begin : receiver
    int mode;
    int len;
    forever begin
      mode = $urandom_range(0, 3);
      len  = $urandom_range(4, 40);
      for (int i = 0; i < len; i++) begin
        if (!hold_done && jobs_in >= HOLD_AT) begin
          out_tready <= 1'b0;
          repeat (HOLD_CYCLES) @(posedge clk);
          hold_done = 1'b1;
        end
        case (mode)
          0:       out_tready <= 1'b1;
          1:       out_tready <= 1'($urandom_range(0, 1));
          2:       out_tready <= (i % 4 != 0);
          default: out_tready <= (i >= len / 2);
        endcase
        @(posedge clk);
      end
    end
  end

  initial begin : stimulus
    job_t job;
    res_t r;
    int   bsize;
    int   pmode;
    int   bmode;
    int   pbase;
    int   random_jobs;
    rst_n         <= 1'b0;
    in_tvalid     <= 1'b0;
    in_tdata      <= '0;
    in_tlast      <= 1'b0;
    jobs_in       = 0;
    batches_done  = 0;
    drop_batches  = 0;
    burst_left    = 0;
    batch_dropped = 1'b0;
    random_jobs   = 0;

    // single all-zero job, then single all-ones job
    dir_rows.push_back('{job: '{prio: 8'h00, burst: 16'h0000, id: 16'h0000},
                         last: 1'b1, typed: 1'b1, exp_res: '0});
    r                 = '0;
    r.job_id_res      = 16'hFFFF;
    r.burst_time_res  = 16'hFFFF;
    r.turnaround_time = 20'h0FFFF;
    r.avg_turnaround  = 28'h0FFFF00;
    dir_rows.push_back('{job: '{prio: 8'hFF, burst: 16'hFFFF, id: 16'hFFFF},
                         last: 1'b1, typed: 1'b1, exp_res: r});
    // equal priorities keep arrival order
    dir_rows.push_back('{job: '{prio: 8'd5, burst: 16'd10, id: 16'd1},
                         last: 1'b0, typed: 1'b0, exp_res: '0});
    dir_rows.push_back('{job: '{prio: 8'd9, burst: 16'd20, id: 16'd2},
                         last: 1'b0, typed: 1'b0, exp_res: '0});
    dir_rows.push_back('{job: '{prio: 8'd5, burst: 16'd30, id: 16'd3},
                         last: 1'b0, typed: 1'b0, exp_res: '0});
    dir_rows.push_back('{job: '{prio: 8'd9, burst: 16'd40, id: 16'd4},
                         last: 1'b1, typed: 1'b0, exp_res: '0});
    // table full, the seventeenth job carries last and is dropped
    for (int i = 0; i <= JOBS_CAP; i++) begin
      dir_rows.push_back('{job: '{prio: 8'(i % 3), burst: 16'hFFFF - 16'(i),
                                  id: 16'h0100 + 16'(i)},
                           last: (i == JOBS_CAP), typed: 1'b0, exp_res: '0});
    end
    // drop flag must be clear again for the next batch
    r                 = '0;
    r.job_id_res      = 16'hA5A5;
    r.burst_time_res  = 16'd1;
    r.turnaround_time = 20'd1;
    r.avg_turnaround  = 28'd256;
    dir_rows.push_back('{job: '{prio: 8'h80, burst: 16'd1, id: 16'hA5A5},
                         last: 1'b1, typed: 1'b1, exp_res: r});

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    foreach (dir_rows[i])
      send_job(dir_rows[i].job, dir_rows[i].last, dir_rows[i].typed, dir_rows[i].exp_res);

    while (random_jobs < RANDOM_ITEMS) begin
      case ($urandom_range(0, 9))
        0:       bsize = JOBS_CAP;
        1:       bsize = $urandom_range(JOBS_CAP + 1, JOBS_CAP + 4);
        default: bsize = $urandom_range(1, 12);
      endcase
      pmode = $urandom_range(0, 2);
      bmode = $urandom_range(0, 3);
      pbase = $urandom_range(0, 255);
      for (int i = 0; i < bsize; i++) begin
        job.id = 16'($urandom);
        case (bmode)
          0:       job.burst = 16'hFFFF;
          1:       job.burst = 16'($urandom_range(0, 15));
          default: job.burst = 16'($urandom);
        endcase
        case (pmode)
          0:       job.prio = 8'($urandom);
          1:       job.prio = 8'($urandom_range(0, 3));   // lots of ties
          default: job.prio = 8'(pbase);
        endcase
        send_job(job, i == bsize - 1, 1'b0, '0);
        random_jobs++;
      end
    end
    in_tvalid <= 1'b0;
    in_tlast  <= 1'b0;

    while (pending_results.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("loaded %0d jobs in %0d batches (%0d with dropped jobs), checked %0d results",
             jobs_in, batches_done, drop_batches, results_seen);
    if (mismatches == 0) begin
      $display("tb_priority_batch_scheduler_unit passed");
    end else begin
      $display("tb_priority_batch_scheduler_unit failed");
    end
    $finish;
  end

endmodule

// ===== files.f =====
hw/rtl/pbs_pkg.sv
hw/rtl/priority_batch_scheduler_unit.sv
tb/tb_priority_batch_scheduler_unit.sv
